// ----- design/pht_pkg.sv -----
// Shared types and constants for the pointer hash table tracker.
// Request and result layouts, status and mode codes, hash constants.
// No dependencies.
`default_nettype none

package pht_pkg;

    // Field widths fixed by the request and result formats
    localparam int ADDR_W   = 64;
    localparam int SIZE_W   = 32;
    localparam int TS_W     = 11;
    localparam int COUNT_W  = 11;
    localparam int TOTAL_W  = 43;
    localparam int STATUS_W = 2;
    localparam int HASH_W   = 32;

    // Remainder unit: hash bits consumed per cycle, number of remainder steps
    localparam int MOD_BITS   = 4;
    localparam int MOD_STEPS  = HASH_W / MOD_BITS;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    // Table size after reset
    localparam logic [TS_W-1:0] TABLE_SIZE_RST = 11'd1024;

    // Request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 2'd3;

    // Hash shift amounts and multiplier
    localparam int HASH_SH_A = 15;
    localparam int HASH_SH_B = 12;
    localparam int HASH_SH_C = 2;
    localparam int HASH_SH_D = 4;
    localparam int HASH_SH_E = 16;
    localparam logic [HASH_W-1:0] HASH_MUL = 32'd2057;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] entry_size;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
        logic [TOTAL_W-1:0]  total_bytes;
        logic [COUNT_W-1:0]  longest_probe;
    } res_t;

endpackage

`default_nettype wire

// ----- design/pht_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the key and size stores of the tracker. No dependencies.
`default_nettype none

module pht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/pointer_hash_table_tracker_core.sv -----
// Allocation tracker: open-addressing hash table with linear probing, top level.
// Depends on pht_pkg (types, codes, hash constants) and pht_ram (key and size stores).
//
// After reset the block sweeps the key store to empty, one slot a cycle over all SLOTS
// slots, holding in_stall high; table_size writes are taken during the sweep. Each
// request then runs the hashing, the remainder (4 hash bits a cycle against cap - 1,
// cap being table_size held to 2..SLOTS), a read and a compare for every slot examined
// (the single read port of the key store: address, then compare), an update of the
// totals when the request succeeds, and the loading of the result. A request with a
// zero address goes straight to the result and fails. The result sits in an output
// register, so the next request is taken while an earlier result is still stalled.
`default_nettype none

module pointer_hash_table_tracker_core #(
    parameter int SLOTS = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire pht_pkg::req_t       in_data,
    // result channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output pht_pkg::res_t            out_data,
    // table_size write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [10:0]         cfg_data
);

    import pht_pkg::*;

    localparam int IW = $clog2(SLOTS);

    // Sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH1  = 4'd2;
    localparam logic [3:0] S_HASH2  = 4'd3;
    localparam logic [3:0] S_HASH3  = 4'd4;
    localparam logic [3:0] S_MOD    = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_COMMIT = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [TS_W-1:0]       table_size_reg;
    req_t                  req_reg, req_next;
    logic [HASH_W-1:0]     h_reg, h_next;
    logic [TS_W-1:0]       rem_reg, rem_next;
    logic [MOD_CNT_W-1:0]  mod_cnt_reg, mod_cnt_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [COUNT_W-1:0]    n_reg, n_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic signed [SIZE_W:0] delta_reg, delta_next;
    logic [COUNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [COUNT_W-1:0]    probe_limit_reg, probe_limit_next;
    logic [TOTAL_W-1:0]    byte_total_reg, byte_total_next;
    logic [IW-1:0]         clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_data_reg, out_data_next;

    logic [TS_W-1:0]       cap_w;
    logic [TS_W-1:0]       div_w;
    logic [TS_W-1:0]       lim_w;
    logic [TS_W-1:0]       rem_step;
    logic [IW-1:0]         idx_wrap;
    logic [HASH_W-1:0]     hash_a, hash_b, hash_c, hash_d, hash_e, hash_f;
    logic                  key_empty, key_match;
    logic                  out_free;

    logic                  key_wr_en;
    logic [IW-1:0]         key_wr_addr;
    logic [ADDR_W-1:0]     key_wr_data;
    logic                  size_wr_en;
    logic                  rd_en;
    logic [ADDR_W-1:0]     key_rd_data;
    logic [SIZE_W-1:0]     size_rd_data;

    // Key and size stores
    pht_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (key_rd_data)
    );

    pht_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_size_ram (
        .clk     (clk),
        .wr_en   (size_wr_en),
        .wr_addr (idx_reg),
        .wr_data (req_reg.entry_size),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (size_rd_data)
    );

    // Effective capacity, hash modulus and remove search length
    always_comb
    begin
        if (table_size_reg < 11'd2)
        begin
            cap_w = 11'd2;
        end
        else if (32'(table_size_reg) > SLOTS)
        begin
            cap_w = 11'(SLOTS);
        end
        else
        begin
            cap_w = table_size_reg;
        end
        div_w = cap_w - 11'd1;
        lim_w = (probe_limit_reg < cap_w) ? probe_limit_reg : cap_w;
    end

    // Hash datapath, split over the states S_HASH1 to S_HASH3
    always_comb
    begin
        hash_a = ~h_reg + (h_reg << HASH_SH_A);
        hash_b = hash_a ^ (hash_a >> HASH_SH_B);
        hash_c = h_reg + (h_reg << HASH_SH_C);
        hash_d = hash_c ^ (hash_c >> HASH_SH_D);
        hash_e = h_reg * HASH_MUL;
        hash_f = hash_e ^ (hash_e >> HASH_SH_E);
    end

    // Remainder unit: four restoring steps per cycle on narrow values
    always_comb
    begin
        logic [TS_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < MOD_BITS; i++)
        begin
            r = {r[TS_W-1:0], h_reg[HASH_W-1-i]};
            if (r >= {1'b0, div_w})
            begin
                r = r - {1'b0, div_w};
            end
        end
        rem_step = r[TS_W-1:0];
    end

    // Linear probe step with wrap at capacity
    always_comb
    begin
        if (32'(idx_reg) + 32'd1 >= 32'(cap_w))
        begin
            idx_wrap = '0;
        end
        else
        begin
            idx_wrap = IW'(32'(idx_reg) + 32'd1);
        end
    end

    assign key_empty = (key_rd_data == '0);
    assign key_match = (key_rd_data == req_reg.address);
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        h_next           = h_reg;
        rem_next         = rem_reg;
        mod_cnt_next     = mod_cnt_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        status_next      = status_reg;
        delta_next       = delta_reg;
        entry_count_next = entry_count_reg;
        probe_limit_next = probe_limit_reg;
        byte_total_next  = byte_total_reg;
        clr_next         = clr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;
        key_wr_en        = 1'b0;
        key_wr_addr      = idx_reg;
        key_wr_data      = req_reg.address;
        size_wr_en       = 1'b0;
        rd_en            = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                key_wr_en   = 1'b1;
                key_wr_addr = clr_reg;
                key_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = in_data;
                    h_next      = in_data.address[HASH_W-1:0];
                    status_next = ST_FAILED;
                    state_next  = (in_data.address == '0) ? S_DONE : S_HASH1;
                end
            end
            S_HASH1:
            begin
                h_next     = hash_b;
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                h_next     = hash_d;
                state_next = S_HASH3;
            end
            S_HASH3:
            begin
                h_next       = hash_f;
                rem_next     = '0;
                mod_cnt_next = '0;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                rem_next     = rem_step;
                h_next       = h_reg << MOD_BITS;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    idx_next = IW'(rem_step);
                    n_next   = 11'd1;
                    if (req_reg.mode == MODE_REMOVE && lim_w == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (req_reg.mode == MODE_INSERT)
                begin
                    if (key_empty || key_match || n_reg == cap_w)
                    begin
                        if (n_reg > probe_limit_reg)
                        begin
                            probe_limit_next = n_reg;
                        end
                    end
                    if (key_empty)
                    begin
                        key_wr_en   = 1'b1;
                        size_wr_en  = 1'b1;
                        status_next = ST_INSERTED;
                        delta_next  = $signed({1'b0, req_reg.entry_size});
                        state_next  = S_COMMIT;
                    end
                    else if (key_match)
                    begin
                        size_wr_en  = 1'b1;
                        status_next = ST_UPDATED;
                        delta_next  = $signed({1'b0, req_reg.entry_size})
                                    - $signed({1'b0, size_rd_data});
                        state_next  = S_COMMIT;
                    end
                    else if (n_reg == cap_w)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_wrap;
                        n_next     = n_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    if (key_match)
                    begin
                        key_wr_en   = 1'b1;
                        key_wr_data = '0;
                        status_next = ST_REMOVED;
                        delta_next  = -$signed({1'b0, size_rd_data});
                        state_next  = S_COMMIT;
                    end
                    else if (n_reg == lim_w)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_wrap;
                        n_next     = n_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_COMMIT:
            begin
                byte_total_next = byte_total_reg
                                + {{(TOTAL_W-SIZE_W-1){delta_reg[SIZE_W]}}, delta_reg};
                if (status_reg == ST_INSERTED)
                begin
                    entry_count_next = entry_count_reg + 1'b1;
                end
                else if (status_reg == ST_REMOVED)
                begin
                    entry_count_next = entry_count_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.live_count    = entry_count_reg;
                    out_data_next.total_bytes   = byte_total_reg;
                    out_data_next.longest_probe = probe_limit_reg;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            table_size_reg  <= TABLE_SIZE_RST;
            entry_count_reg <= '0;
            probe_limit_reg <= '0;
            byte_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            entry_count_reg <= entry_count_next;
            probe_limit_reg <= probe_limit_next;
            byte_total_reg  <= byte_total_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                table_size_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        h_reg        <= h_next;
        rem_reg      <= rem_next;
        mod_cnt_reg  <= mod_cnt_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        status_reg   <= status_next;
        delta_reg    <= delta_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // Checks
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> 32'(idx_reg) < 32'(cap_w))
        else $error("probe index beyond capacity");

    a_commit_not_failed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMMIT |-> status_reg != ST_FAILED)
        else $error("commit of a failed request");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && status_reg == ST_REMOVED) |-> entry_count_reg != '0)
        else $error("remove with no live records");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(entry_count_reg) <= SLOTS)
        else $error("live count exceeds table slots");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded");

endmodule

`default_nettype wire
